// ===== rtl/imu_frame_tilt_angles_macros.svh =====
// assertion macros for the imu frame tilt block
// used by the top level; no other dependencies
`ifndef IMU_FRAME_TILT_ANGLES_MACROS_SVH
`define IMU_FRAME_TILT_ANGLES_MACROS_SVH

// same-cycle implication, idle during reset
`define IFTA_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, idle during reset
`define IFTA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/ifta_pkg.sv =====
// shared types, constants and the arctangent table for the tilt block
// no dependencies
`timescale 1ns / 1ps

package ifta_pkg;

   localparam int CORDIC_STEPS = 16;
   localparam int TABLE_LEN = 24;
   localparam int STEPS_USED = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
   localparam int FRAME_BYTES = 14;
   localparam logic [3:0] LAST_BYTE = 4'(FRAME_BYTES - 1);

   localparam int CW = 28;   // cordic x/y width
   localparam int ZW = 29;   // cordic angle accumulator width
   localparam int RAD_W = 52;
   localparam int ROOT_W = RAD_W / 2;

   localparam logic signed [ZW-1:0] HALF_TURN = ZW'(73728000);
   localparam logic signed [16:0] ROLL_LIMIT = 17'sd18000;
   localparam logic signed [16:0] PITCH_LIMIT = 17'sd9000;

   localparam logic [2:0] REG_ACCEL_X = 3'd0;
   localparam logic [2:0] REG_ACCEL_Y = 3'd1;
   localparam logic [2:0] REG_ACCEL_Z = 3'd2;
   localparam logic [2:0] REG_RATE_ROLL = 3'd3;
   localparam logic [2:0] REG_RATE_PITCH = 3'd4;
   localparam logic [2:0] REG_RATE_YAW = 3'd5;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_SQRT_MAG,
      ST_SQRT_TILT,
      ST_CORD_ROLL,
      ST_CORD_PITCH
   } state_type;

   // atan(2^-i) in units of 1/4096 hundredth of a degree
   function automatic logic signed [ZW-1:0] atan_entry(input logic [4:0] idx);
      logic signed [ZW-1:0] v;
      begin
         case (idx)
            5'd0: v = ZW'(18432000);
            5'd1: v = ZW'(10881045);
            5'd2: v = ZW'(5749245);
            5'd3: v = ZW'(2918407);
            5'd4: v = ZW'(1464867);
            5'd5: v = ZW'(733147);
            5'd6: v = ZW'(366663);
            5'd7: v = ZW'(183343);
            5'd8: v = ZW'(91673);
            5'd9: v = ZW'(45837);
            5'd10: v = ZW'(22918);
            5'd11: v = ZW'(11459);
            5'd12: v = ZW'(5730);
            5'd13: v = ZW'(2865);
            5'd14: v = ZW'(1432);
            5'd15: v = ZW'(716);
            5'd16: v = ZW'(358);
            5'd17: v = ZW'(179);
            5'd18: v = ZW'(90);
            5'd19: v = ZW'(45);
            5'd20: v = ZW'(22);
            5'd21: v = ZW'(11);
            5'd22: v = ZW'(6);
            5'd23: v = ZW'(3);
            default: v = '0;
         endcase
         return v;
      end
   endfunction

endpackage

// ===== rtl/ifta_isqrt.sv =====
// bit-serial integer square root, one root bit per cycle
// depends on ifta_pkg
`timescale 1ns / 1ps

module ifta_isqrt (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [ifta_pkg::RAD_W-1:0]   radicand,
   output logic                         done,
   output logic [ifta_pkg::ROOT_W-1:0]  root
);

   localparam int RW = ifta_pkg::ROOT_W + 2;

   logic [ifta_pkg::RAD_W-1:0] rad_ff, rad_in;
   logic [RW-1:0] rem_ff, rem_in;
   logic [ifta_pkg::ROOT_W-1:0] root_ff, root_in;
   logic [4:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic [RW+1:0] rem_shift;
   logic [RW+1:0] trial;

   // one restoring step: bring down two radicand bits, try the next root bit
   always_comb begin
      rem_shift = {rem_ff, rad_ff[ifta_pkg::RAD_W-1 -: 2]};
      trial = {2'b00, root_ff, 2'b01};
      rad_in = rad_ff;
      rem_in = rem_ff;
      root_in = root_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rad_in = radicand;
         rem_in = '0;
         root_in = '0;
         cnt_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in = {rad_ff[ifta_pkg::RAD_W-3:0], 2'b00};
         if (rem_shift >= trial) begin
            rem_in = RW'(rem_shift - trial);
            root_in = {root_ff[ifta_pkg::ROOT_W-2:0], 1'b1};
         end else begin
            rem_in = RW'(rem_shift);
            root_in = {root_ff[ifta_pkg::ROOT_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'(ifta_pkg::ROOT_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      rad_ff <= rad_in;
      rem_ff <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

// ===== rtl/ifta_cordic.sv =====
// iterative vectoring cordic, one micro-rotation per cycle
// depends on ifta_pkg
`timescale 1ns / 1ps

module ifta_cordic (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic                               pitch_sel,
   input  logic signed [ifta_pkg::CW-1:0]     x_start,
   input  logic signed [ifta_pkg::CW-1:0]     y_start,
   output logic                               done,
   output logic signed [15:0]                 angle
);

   logic signed [ifta_pkg::CW-1:0] x_ff, x_in, y_ff, y_in, xs, ys;
   logic signed [ifta_pkg::ZW-1:0] z_ff, z_in, tab, z_round;
   logic [4:0] step_ff, step_in;
   logic busy_ff, busy_in, done_ff, done_in;
   logic zero_ff, zero_in, pitch_ff, pitch_in;
   logic signed [16:0] hund, lim, clamped;

   // load with half-turn fold, then rotate toward the x axis
   always_comb begin
      xs = x_ff >>> step_ff;
      ys = y_ff >>> step_ff;
      tab = ifta_pkg::atan_entry(step_ff);
      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      zero_in = zero_ff;
      pitch_in = pitch_ff;
      if (start) begin
         zero_in = (x_start == '0) && (y_start == '0);
         pitch_in = pitch_sel;
         step_in = '0;
         busy_in = 1'b1;
         if (x_start < 0) begin
            z_in = (y_start >= 0) ? ifta_pkg::HALF_TURN : -ifta_pkg::HALF_TURN;
            x_in = -x_start;
            y_in = -y_start;
         end else begin
            z_in = '0;
            x_in = x_start;
            y_in = y_start;
         end
      end else if (busy_ff) begin
         if (y_ff >= 0) begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + tab;
         end else begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - tab;
         end
         step_in = step_ff + 5'd1;
         if (step_ff == 5'(ifta_pkg::STEPS_USED - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
      zero_ff <= zero_in;
      pitch_ff <= pitch_in;
   end

   // round to hundredths and clamp, or zero for a zero input vector
   always_comb begin
      z_round = z_ff + ifta_pkg::ZW'(2048);
      hund = 17'(z_round >>> 12);
      lim = pitch_ff ? ifta_pkg::PITCH_LIMIT : ifta_pkg::ROLL_LIMIT;
      if (zero_ff) begin
         clamped = '0;
      end else if (hund > lim) begin
         clamped = lim;
      end else if (hund < -lim) begin
         clamped = -lim;
      end else begin
         clamped = hund;
      end
   end

   assign done = done_ff;
   assign angle = clamped[15:0];

endmodule

// ===== rtl/imu_frame_tilt_angles.sv =====
// top level: frame byte assembly, offset correction, squares and sequencing
// depends on ifta_pkg, ifta_isqrt, ifta_cordic and the assertion macro header
// Bytes are taken only while the sequencer is idle and no result is waiting.
// The last byte of a frame starts the squares, two square roots on the shared
// bit-serial root unit and two runs of the shared cordic; no byte is taken
// until the result has been taken. Synchronous active-high reset restores the
// offsets and clears the byte count; stored frame words are undefined until
// written.
`timescale 1ns / 1ps
`include "imu_frame_tilt_angles_macros.svh"

module imu_frame_tilt_angles (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [7:0]    req_tdata,    // data_byte[7:0]
   input  logic          req_tuser,    // frame_start
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // tilt_roll, tilt_pitch, accel_magnitude, accel_x, accel_y, accel_z,
   // temperature_raw, rate_roll, rate_pitch, rate_yaw, then zero fill
   output logic [167:0]  rsp_tdata,
   input  logic          csr_we,
   input  logic [2:0]    csr_index,
   input  logic [15:0]   csr_wdata
);

   ifta_pkg::state_type state_ff, state_in;

   logic [15:0] off_ff [6];
   logic [15:0] words_ff [6];
   logic [3:0] byte_pos_ff;
   logic [7:0] pending_ff;
   logic [3:0] pos_raw, pos;
   logic req_acc, last_acc;
   logic [15:0] word;

   logic signed [16:0] ax_ff, ay_ff, az_ff, rr_ff, rp_ff, ry_ff;
   logic [15:0] temp_ff;
   logic [1:0] mul_cnt_ff;
   logic signed [16:0] mul_op;
   logic signed [33:0] mul_full;
   logic [32:0] prod_ff;
   logic [33:0] acc_ff;

   logic sqrt_start, sqrt_done;
   logic [ifta_pkg::RAD_W-1:0] radicand;
   logic [ifta_pkg::ROOT_W-1:0] root;
   logic [16:0] mag_ff;
   logic [24:0] r_ff;

   logic cord_start, cord_done, pitch_sel;
   logic signed [ifta_pkg::CW-1:0] cx, cy;
   logic signed [15:0] angle;
   logic signed [15:0] roll_ff;
   logic signed [17:0] neg_ax;

   logic rsp_tvalid_ff;
   logic [167:0] rsp_tdata_ff;

   // byte position for this item
   always_comb begin
      pos_raw = req_tuser ? 4'd0 : byte_pos_ff;
      pos = (pos_raw > ifta_pkg::LAST_BYTE) ? 4'd0 : pos_raw;
      word = {pending_ff, req_tdata};
      req_acc = req_tvalid && req_tready;
      last_acc = req_acc && (pos == ifta_pkg::LAST_BYTE);
   end

   // offset registers
   always_ff @(posedge clock) begin
      if (reset) begin
         off_ff[ifta_pkg::REG_ACCEL_X] <= 16'hF7A4;
         off_ff[ifta_pkg::REG_ACCEL_Y] <= 16'd125;
         off_ff[ifta_pkg::REG_ACCEL_Z] <= 16'd210;
         off_ff[ifta_pkg::REG_RATE_ROLL] <= 16'hFB0A;
         off_ff[ifta_pkg::REG_RATE_PITCH] <= 16'd210;
         off_ff[ifta_pkg::REG_RATE_YAW] <= 16'd52;
      end else if (csr_we && (csr_index <= ifta_pkg::REG_RATE_YAW)) begin
         off_ff[csr_index] <= csr_wdata;
      end
   end

   // byte count and high byte
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_pos_ff <= '0;
         pending_ff <= '0;
      end else if (req_acc) begin
         byte_pos_ff <= (pos == ifta_pkg::LAST_BYTE) ? 4'd0 : pos + 4'd1;
         if (!pos[0]) begin
            pending_ff <= req_tdata;
         end
      end
   end

   // frame words
   always_ff @(posedge clock) begin
      if (req_acc && pos[0] && (pos != ifta_pkg::LAST_BYTE)) begin
         words_ff[pos[3:1]] <= word;
      end
   end

   // offset correction on the last byte
   always_ff @(posedge clock) begin
      if (last_acc) begin
         ax_ff <= $signed({words_ff[0][15], words_ff[0]})
                  - $signed({off_ff[ifta_pkg::REG_ACCEL_X][15], off_ff[ifta_pkg::REG_ACCEL_X]});
         ay_ff <= $signed({words_ff[1][15], words_ff[1]})
                  - $signed({off_ff[ifta_pkg::REG_ACCEL_Y][15], off_ff[ifta_pkg::REG_ACCEL_Y]});
         az_ff <= $signed({words_ff[2][15], words_ff[2]})
                  - $signed({off_ff[ifta_pkg::REG_ACCEL_Z][15], off_ff[ifta_pkg::REG_ACCEL_Z]});
         temp_ff <= words_ff[3];
         rr_ff <= $signed({words_ff[4][15], words_ff[4]})
                  - $signed({off_ff[ifta_pkg::REG_RATE_ROLL][15],
                             off_ff[ifta_pkg::REG_RATE_ROLL]});
         rp_ff <= $signed({words_ff[5][15], words_ff[5]})
                  - $signed({off_ff[ifta_pkg::REG_RATE_PITCH][15],
                             off_ff[ifta_pkg::REG_RATE_PITCH]});
         ry_ff <= $signed({word[15], word})
                  - $signed({off_ff[ifta_pkg::REG_RATE_YAW][15], off_ff[ifta_pkg::REG_RATE_YAW]});
      end
   end

   // shared squarer: ay^2, az^2, ax^2 one per cycle
   always_comb begin
      case (mul_cnt_ff)
         2'd0: mul_op = ay_ff;
         2'd1: mul_op = az_ff;
         default: mul_op = ax_ff;
      endcase
      mul_full = mul_op * mul_op;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_cnt_ff <= '0;
      end else if (state_ff == ifta_pkg::ST_SQUARE) begin
         mul_cnt_ff <= mul_cnt_ff + 2'd1;
      end else begin
         mul_cnt_ff <= '0;
      end
   end

   // accumulate ay^2 + az^2; the magnitude adds ax^2 on the fly
   always_ff @(posedge clock) begin
      if (state_ff == ifta_pkg::ST_SQUARE) begin
         prod_ff <= mul_full[32:0];
         case (mul_cnt_ff)
            2'd0: acc_ff <= '0;
            2'd1: acc_ff <= {1'b0, prod_ff};
            2'd2: acc_ff <= acc_ff + {1'b0, prod_ff};
            default: acc_ff <= acc_ff;
         endcase
      end
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ifta_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ifta_pkg::ST_IDLE: if (last_acc) state_in = ifta_pkg::ST_SQUARE;
         ifta_pkg::ST_SQUARE: if (mul_cnt_ff == 2'd3) state_in = ifta_pkg::ST_SQRT_MAG;
         ifta_pkg::ST_SQRT_MAG: if (sqrt_done) state_in = ifta_pkg::ST_SQRT_TILT;
         ifta_pkg::ST_SQRT_TILT: if (sqrt_done) state_in = ifta_pkg::ST_CORD_ROLL;
         ifta_pkg::ST_CORD_ROLL: if (cord_done) state_in = ifta_pkg::ST_CORD_PITCH;
         ifta_pkg::ST_CORD_PITCH: if (cord_done) state_in = ifta_pkg::ST_IDLE;
         default: state_in = ifta_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_tready = (state_ff == ifta_pkg::ST_IDLE) && !rsp_tvalid_ff;
      sqrt_start = ((state_ff == ifta_pkg::ST_SQUARE) && (mul_cnt_ff == 2'd3))
                   || ((state_ff == ifta_pkg::ST_SQRT_MAG) && sqrt_done);
      cord_start = ((state_ff == ifta_pkg::ST_SQRT_TILT) && sqrt_done)
                   || ((state_ff == ifta_pkg::ST_CORD_ROLL) && cord_done);
      pitch_sel = (state_ff == ifta_pkg::ST_CORD_ROLL);
   end

   // root operand: full magnitude first, then (ay^2+az^2) scaled by 2^16
   always_comb begin
      if (state_ff == ifta_pkg::ST_SQUARE) begin
         radicand = {18'b0, acc_ff + {1'b0, prod_ff}};
      end else begin
         radicand = {2'b0, acc_ff, 16'b0};
      end
   end

   ifta_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (radicand),
      .done     (sqrt_done),
      .root     (root)
   );

   // cordic operands: roll vectors (az, ay), pitch vectors (r, -ax)
   always_comb begin
      neg_ax = -$signed({ax_ff[16], ax_ff});
      if (pitch_sel) begin
         cx = $signed({3'b0, r_ff});
         cy = $signed({{2{neg_ax[17]}}, neg_ax, 8'b0});
      end else begin
         cx = $signed({{3{az_ff[16]}}, az_ff, 8'b0});
         cy = $signed({{3{ay_ff[16]}}, ay_ff, 8'b0});
      end
   end

   ifta_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .start     (cord_start),
      .pitch_sel (pitch_sel),
      .x_start   (cx),
      .y_start   (cy),
      .done      (cord_done),
      .angle     (angle)
   );

   // intermediate results
   always_ff @(posedge clock) begin
      if ((state_ff == ifta_pkg::ST_SQRT_MAG) && sqrt_done) begin
         mag_ff <= root[16:0];
      end
      if ((state_ff == ifta_pkg::ST_SQRT_TILT) && sqrt_done) begin
         r_ff <= root[24:0];
      end
      if ((state_ff == ifta_pkg::ST_CORD_ROLL) && cord_done) begin
         roll_ff <= angle;
      end
   end

   // output item register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if ((state_ff == ifta_pkg::ST_CORD_PITCH) && cord_done) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == ifta_pkg::ST_CORD_PITCH) && cord_done) begin
         rsp_tdata_ff <= {2'b0, ry_ff, rp_ff, rr_ff, temp_ff, az_ff, ay_ff, ax_ff,
                          mag_ff, angle[14:0], roll_ff};
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata = rsp_tdata_ff;

   `IFTA_ASSERT_NOW(a_pos_range, 1'b1, byte_pos_ff <= ifta_pkg::LAST_BYTE, "byte position out of range")
   `IFTA_ASSERT_NOW(a_busy_no_out, state_ff != ifta_pkg::ST_IDLE, !rsp_tvalid_ff, "result pending while busy")
   `IFTA_ASSERT_NEXT(a_done_out, (state_ff == ifta_pkg::ST_CORD_PITCH) && cord_done, rsp_tvalid_ff && (state_ff == ifta_pkg::ST_IDLE), "result not presented")

endmodule

// ===== verif/imu_frame_tilt_angles_tb.sv =====
// testbench for imu_frame_tilt_angles: byte frames in, tilt result items out
// depends on ifta_pkg and the imu_frame_tilt_angles rtl; self-checking via its own predictor
`timescale 1ns / 1ps

module imu_frame_tilt_angles_tb;

   localparam logic [2:0] REG_UNUSED = 3'd7;
   localparam int SETTLE_CYCLES = 150;
   localparam int PHASE_ITEMS = 275;

   typedef struct packed {
      logic [16:0] rate_yaw;
      logic [16:0] rate_pitch;
      logic [16:0] rate_roll;
      logic [15:0] temp;
      logic [16:0] az;
      logic [16:0] ay;
      logic [16:0] ax;
      logic [16:0] mag;
      logic [14:0] pitch;
      logic [15:0] roll;
   } tilt_result_type;

   typedef struct packed {
      logic [7:0] data;
      logic       start;
   } frame_byte_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [7:0]    req_tdata = '0;   // data_byte[7:0]
   logic          req_tuser = 1'b0; // frame_start
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   // tilt_roll, tilt_pitch, accel_magnitude, accel_x, accel_y, accel_z,
   // temperature_raw, rate_roll, rate_pitch, rate_yaw, then zero fill
   logic [167:0]  rsp_tdata;
   logic          csr_we = 1'b0;
   logic [2:0]    csr_index = '0;
   logic [15:0]   csr_wdata = '0;

   imu_frame_tilt_angles u_dut (.*);

   // clock
   initial begin
      forever #5 clock = ~clock;
   end

   // predictor state
   logic signed [15:0] offs [6];
   logic [15:0]        words [6];
   int unsigned        byte_pos;
   logic [7:0]         high_byte;

   frame_byte_type  pending_bytes [$];
   tilt_result_type tilt_expected [$];
   int              mismatches = 0;
   int unsigned     cycle_count = 0;

   function automatic longint unsigned int_sqrt(longint unsigned n);
      longint unsigned root, bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (n >= root + bitv) begin
            n = n - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root;
   endfunction

   // vectoring cordic, result in hundredths of a degree, clamped
   function automatic longint cordic_atan2(longint y, longint x, longint lim);
      longint z, xs, ys, h;
      int steps;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         z = (y >= 0) ? longint'(ifta_pkg::HALF_TURN) : -longint'(ifta_pkg::HALF_TURN);
         x = -x;
         y = -y;
      end
      steps = (ifta_pkg::CORDIC_STEPS > ifta_pkg::TABLE_LEN) ? ifta_pkg::TABLE_LEN
                                                             : ifta_pkg::CORDIC_STEPS;
      for (int i = 0; i < steps; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y >= 0) begin
            x = x + ys; y = y - xs; z = z + longint'(ifta_pkg::atan_entry(5'(i)));
         end else begin
            x = x - ys; y = y + xs; z = z - longint'(ifta_pkg::atan_entry(5'(i)));
         end
      end
      h = (z + 2048) >>> 12;
      if (h > lim) h = lim;
      if (h < -lim) h = -lim;
      return h;
   endfunction

   // advance the frame assembler by one byte, queue a result on the last byte
   task automatic assemble_byte(frame_byte_type fb);
      int unsigned pos;
      logic [15:0] word;
      longint ax, ay, az, s, r;
      tilt_result_type res;
      pos = fb.start ? 0 : byte_pos;
      if (pos >= ifta_pkg::FRAME_BYTES) pos = 0;
      byte_pos = (pos == ifta_pkg::FRAME_BYTES - 1) ? 0 : pos + 1;
      if (pos[0] == 1'b0) begin
         high_byte = fb.data;
         return;
      end
      word = {high_byte, fb.data};
      if ((pos >> 1) < 6) begin
         words[pos >> 1] = word;
         return;
      end
      ax = longint'($signed(words[0])) - longint'(offs[ifta_pkg::REG_ACCEL_X]);
      ay = longint'($signed(words[1])) - longint'(offs[ifta_pkg::REG_ACCEL_Y]);
      az = longint'($signed(words[2])) - longint'(offs[ifta_pkg::REG_ACCEL_Z]);
      s = ay * ay + az * az;
      r = longint'(int_sqrt(longint'(s) << 16));
      res.roll = 16'(cordic_atan2(ay * 256, az * 256, 18000));
      res.pitch = 15'(cordic_atan2(-ax * 256, r, 9000));
      res.mag = 17'(int_sqrt(s + ax * ax));
      res.ax = 17'(ax);
      res.ay = 17'(ay);
      res.az = 17'(az);
      res.temp = words[3];
      res.rate_roll = 17'(longint'($signed(words[4]))
                          - longint'(offs[ifta_pkg::REG_RATE_ROLL]));
      res.rate_pitch = 17'(longint'($signed(words[5]))
                           - longint'(offs[ifta_pkg::REG_RATE_PITCH]));
      res.rate_yaw = 17'(longint'($signed(word)) - longint'(offs[ifta_pkg::REG_RATE_YAW]));
      tilt_expected.push_back(res);
   endtask

   // sender: bursts of random length with random gaps
   int burst_left = 0;
   int gap_left = 0;
   always @(posedge clock) begin
      frame_byte_type fb;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) assemble_byte('{data: req_tdata, start: req_tuser});
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left = gap_left - 1;
               req_tvalid <= 1'b0;
            end else if (pending_bytes.size() > 0) begin
               fb = pending_bytes.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= fb.data;
               req_tuser <= fb.start;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 40);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
               end else begin
                  burst_left = burst_left - 1;
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // receiver: periodically redrawn stall pattern, plus one long hold-off
   int hold_left = 0;
   int stall_mode = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count % 64 == 0) stall_mode = $urandom_range(0, 3);
      if (cycle_count == 4000) hold_left = 700;
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         case (stall_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= ($urandom_range(0, 1) == 0);
            2: rsp_tready <= ($urandom_range(0, 9) != 0);
            default: rsp_tready <= ($urandom_range(0, 9) == 0);
         endcase
      end
   end

   task automatic check_field(string name, logic [16:0] want, logic [16:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch %s: expected %h, got %h", name, want, got);
      end
   endtask

   // result checker
   always @(posedge clock) begin
      tilt_result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = tilt_result_type'(rsp_tdata[165:0]);
         if (tilt_expected.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: unexpected item %h", rsp_tdata);
         end else begin
            want = tilt_expected.pop_front();
            check_field("tilt_roll", 17'(want.roll), 17'(got.roll));
            check_field("tilt_pitch", 17'(want.pitch), 17'(got.pitch));
            check_field("accel_magnitude", want.mag, got.mag);
            check_field("accel_x", want.ax, got.ax);
            check_field("accel_y", want.ay, got.ay);
            check_field("accel_z", want.az, got.az);
            check_field("temperature_raw", 17'(want.temp), 17'(got.temp));
            check_field("rate_roll", want.rate_roll, got.rate_roll);
            check_field("rate_pitch", want.rate_pitch, got.rate_pitch);
            check_field("rate_yaw", want.rate_yaw, got.rate_yaw);
         end
      end
   end

   task automatic write_reg(logic [2:0] idx, logic [15:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      if (idx < 6) offs[idx] = value;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic push_word(logic [15:0] w, logic first);
      pending_bytes.push_back('{data: w[15:8], start: first});
      pending_bytes.push_back('{data: w[7:0], start: 1'b0});
   endtask

   // word near the offset of its axis, at an extreme, or anywhere
   function automatic logic [15:0] pick_word(int slot);
      logic [15:0] base;
      case (slot)
         0: base = offs[ifta_pkg::REG_ACCEL_X];
         1: base = offs[ifta_pkg::REG_ACCEL_Y];
         2: base = offs[ifta_pkg::REG_ACCEL_Z];
         4: base = offs[ifta_pkg::REG_RATE_ROLL];
         5: base = offs[ifta_pkg::REG_RATE_PITCH];
         6: base = offs[ifta_pkg::REG_RATE_YAW];
         default: base = 16'($urandom);
      endcase
      case ($urandom_range(0, 7))
         0: return base;
         1: return base + 16'($urandom_range(0, 8)) - 16'd4;
         2: return 16'h8000;
         3: return 16'h7FFF;
         4: return base + 16'($signed($urandom_range(0, 2000)) - 1000);
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic push_frame(int words_n);
      for (int k = 0; k < words_n; k++) push_word(pick_word(k), k == 0);
   endtask

   task automatic random_traffic(int count);
      int n;
      int w;
      n = 0;
      while (n < count) begin
         case ($urandom_range(0, 9))
            0: begin
               // loose bytes with random frame marks
               for (int k = $urandom_range(1, 5); k > 0; k--) begin
                  pending_bytes.push_back('{data: 8'($urandom), start: 1'($urandom)});
                  n++;
               end
            end
            1: begin
               // frame cut short, then restarted by the next mark
               w = $urandom_range(1, 6);
               push_frame(w);
               n += 2 * w;
               if ($urandom_range(0, 1)) begin
                  pending_bytes.push_back('{data: 8'($urandom), start: 1'b1});
                  n++;
               end
            end
            default: begin
               push_frame(7);
               n += 14;
            end
         endcase
      end
   endtask

   task automatic wait_drained();
      while (pending_bytes.size() != 0 || req_tvalid || tilt_expected.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // stimulus and end of run
   initial begin
      offs = '{-16'sd2140, 16'sd125, 16'sd210, -16'sd1270, 16'sd210, 16'sd52};
      words = '{default: '0};
      byte_pos = 0;
      high_byte = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: partial frame restarted mid-way, then a frame where the
      // roll operands cancel to zero and the pitch x operand is zero
      pending_bytes.push_back('{data: 8'hFF, start: 1'b1});
      pending_bytes.push_back('{data: 8'h00, start: 1'b0});
      pending_bytes.push_back('{data: 8'h7F, start: 1'b0});
      push_word(16'h8000, 1'b1);
      push_word(offs[ifta_pkg::REG_ACCEL_Y], 1'b0);
      push_word(offs[ifta_pkg::REG_ACCEL_Z], 1'b0);
      push_word(16'h7FFF, 1'b0);
      push_word(16'hFFFF, 1'b0);
      push_word(16'h0000, 1'b0);
      push_word(16'h8000, 1'b0);
      // seven more words without a frame mark: count wraps on its own
      push_word(16'h7FFF, 1'b0);
      push_word(16'h0080, 1'b0);
      push_word(16'hFF7F, 1'b0);
      push_word(16'h8000, 1'b0);
      push_word(16'h7FFF, 1'b0);
      push_word(16'h8000, 1'b0);
      push_word(16'h7FFF, 1'b0);
      random_traffic(PHASE_ITEMS - 30);

      for (int phase = 1; phase < 6; phase++) begin
         wait_drained();
         for (int ri = 0; ri < 6; ri++) begin
            case (phase)
               1: write_reg(3'(ri), 16'h0000);
               2: write_reg(3'(ri), 16'h7FFF);
               3: write_reg(3'(ri), 16'h8000);
               4: write_reg(3'(ri), 16'($urandom));
               default: write_reg(3'(ri), (ri % 2) ? 16'h8000 : 16'h7FFF);
            endcase
         end
         if (phase == 5) write_reg(REG_UNUSED, 16'($urandom));
         random_traffic(PHASE_ITEMS);
      end

      wait_drained();
      if (mismatches == 0 && tilt_expected.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // watchdog
   initial begin
      #8_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
